[rtl/skinny_pkg.sv]
// Shared constants and round functions for the SKINNY-64-64 encryption pipeline.
package skinny_pkg;

  typedef logic [3:0]  nib_t;
  typedef logic [63:0] blk_t;
  typedef logic [5:0]  rc_t;

  localparam int NumCells   = 16;
  localparam int MaxRounds  = 32;
  localparam nib_t RowTwoRc = 4'h2;

  // 4-bit S-box.
  localparam nib_t SBOX [NumCells] = '{
    4'hc, 4'h6, 4'h9, 4'h0, 4'h1, 4'ha, 4'h2, 4'hb,
    4'h3, 4'h8, 4'h5, 4'hd, 4'h4, 4'he, 4'h7, 4'hf
  };

  // 6-bit LFSR round constants, one per round.
  localparam rc_t RCONST [MaxRounds] = '{
    6'h01, 6'h03, 6'h07, 6'h0f, 6'h1f, 6'h3e, 6'h3d, 6'h3b,
    6'h37, 6'h2f, 6'h1e, 6'h3c, 6'h39, 6'h33, 6'h27, 6'h0e,
    6'h1d, 6'h3a, 6'h35, 6'h2b, 6'h16, 6'h2c, 6'h18, 6'h30,
    6'h21, 6'h02, 6'h05, 6'h0b, 6'h17, 6'h2e, 6'h1c, 6'h38
  };

  // Tweakey cell permutation: new cell i takes old cell TK_PERM[i].
  localparam int TK_PERM [NumCells] = '{
    9, 15, 8, 13, 10, 14, 12, 11, 0, 1, 2, 3, 4, 5, 6, 7
  };

  // ShiftRows: new cell i takes old cell ROW_SHIFT[i].
  localparam int ROW_SHIFT [NumCells] = '{
    0, 1, 2, 3, 7, 4, 5, 6, 10, 11, 8, 9, 13, 14, 15, 12
  };

  // Source cell of the original tweakey for cell i after r permutations.
  function automatic int tk_src(int r, int i);
    int idx;
    idx = i;
    for (int k = 0; k < r; k++) begin
      idx = TK_PERM[idx];
    end
    return idx;
  endfunction

  // One full round on a block, given the round tweakey (top two rows only).
  function automatic blk_t round_fn(blk_t st, blk_t rtk, rc_t rc);
    nib_t s [NumCells];
    nib_t t [NumCells];
    nib_t a, b, c, d;
    blk_t res;
    // SubCells, then constants and round tweakey.
    for (int i = 0; i < NumCells; i++) begin
      s[i] = SBOX[st[63-4*i -: 4]];
    end
    s[0] = s[0] ^ rc[3:0];
    s[4] = s[4] ^ {2'b00, rc[5:4]};
    s[8] = s[8] ^ RowTwoRc;
    for (int i = 0; i < 8; i++) begin
      s[i] = s[i] ^ rtk[63-4*i -: 4];
    end
    // ShiftRows.
    for (int i = 0; i < NumCells; i++) begin
      t[i] = s[ROW_SHIFT[i]];
    end
    // Binary MixColumns, one column at a time.
    for (int i = 0; i < 4; i++) begin
      a = t[i];
      b = t[4+i];
      c = t[8+i];
      d = t[12+i];
      s[i]    = a ^ c ^ d;
      s[4+i]  = a;
      s[8+i]  = b ^ c;
      s[12+i] = a ^ c;
    end
    for (int i = 0; i < NumCells; i++) begin
      res[63-4*i -: 4] = s[i];
    end
    return res;
  endfunction

endpackage

[rtl/skinny_round_cell.sv]
// One pipeline cell: a registered SKINNY round with its own fixed round tweakey wiring.
module skinny_round_cell #(
  parameter int ROUND_IDX = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic               valid_i,
  input  skinny_pkg::blk_t   state_i,
  input  skinny_pkg::blk_t   tweakey_i,
  output logic               valid_o,
  output skinny_pkg::blk_t   state_o
);
  import skinny_pkg::*;

  blk_t rtk;
  blk_t state_d, state_q;
  logic valid_q;

  // Round tweakey: the top two rows of the tweakey permuted ROUND_IDX times.
  for (genvar g = 0; g < 8; g++) begin : g_rtk
    localparam int Src = tk_src(ROUND_IDX, g);
    assign rtk[63-4*g -: 4] = tweakey_i[63-4*Src -: 4];
  end
  assign rtk[31:0] = '0;

  assign state_d = round_fn(state_i, rtk, RCONST[ROUND_IDX]);

  // Valid bit moves with the pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  // Block state is loaded only when a transaction moves in.
  always_ff @(posedge clk_i) begin
    if (adv_i && valid_i) begin
      state_q <= state_d;
    end
  end

  assign valid_o = valid_q;
  assign state_o = state_q;

endmodule

[rtl/skinny64_64_encrypt_unit.sv]
// Top level of the SKINNY-64-64 encryption pipeline.
// SKINNY-64-64 encryption, one 64-bit block per clock cycle while the output side does not
// stall. Each block passes through a chain of ROUND_COUNT round cells (32 by default), one
// round per cell, and each cell registers it on its way to the output. The last
// cell is the output register; when the output side stalls, the whole chain holds and
// s_axis_tready drops, and it accepts again in the cycle the output is taken. The tweakey
// register is shared by all cells, which derive their round tweakeys by fixed wiring;
// write it only while no block is in flight. Cells are nibbles with cell 0 in bits 63:60.
module skinny64_64_encrypt_unit #(
  parameter int ROUND_COUNT = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [63:0]         s_axis_tdata,   // [63:0] plaintext
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [63:0]         m_axis_tdata,   // [63:0] ciphertext
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [63:0]         cfg_data_i      // [63:0] tweakey
);
  import skinny_pkg::*;

  blk_t tweakey_q;
  logic adv;
  logic [ROUND_COUNT-1:0] vld;
  blk_t state [ROUND_COUNT];

  // Tweakey register, written by a configuration transaction.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tweakey_q <= '0;
    end else if (cfg_valid_i) begin
      tweakey_q <= cfg_data_i;
    end
  end

  // The chain moves whenever the output register is free or being drained.
  assign adv = !vld[ROUND_COUNT-1] || m_axis_tready;
  assign s_axis_tready = adv;

  // Chain of round cells.
  for (genvar r = 0; r < ROUND_COUNT; r++) begin : g_cell
    if (r == 0) begin : g_first
      skinny_round_cell #(.ROUND_IDX(r)) u_cell (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .adv_i     (adv),
        .valid_i   (s_axis_tvalid),
        .state_i   (s_axis_tdata),
        .tweakey_i (tweakey_q),
        .valid_o   (vld[r]),
        .state_o   (state[r])
      );
    end else begin : g_next
      skinny_round_cell #(.ROUND_IDX(r)) u_cell (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .adv_i     (adv),
        .valid_i   (vld[r-1]),
        .state_i   (state[r-1]),
        .tweakey_i (tweakey_q),
        .valid_o   (vld[r]),
        .state_o   (state[r])
      );
    end
  end

  assign m_axis_tvalid = vld[ROUND_COUNT-1];
  assign m_axis_tdata  = state[ROUND_COUNT-1];

  // A stalled chain keeps every occupied cell in place.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld))
    else $error("pipeline valid bits changed during a stall");

  // An accepted input transaction lands in the first cell.
  a_input_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> vld[0])
    else $error("accepted block did not enter the first cell");

  // Each advance shifts the valid bits by one cell.
  if (ROUND_COUNT > 1) begin : g_shift_chk
    a_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
      adv |=> vld[ROUND_COUNT-1:1] == $past(vld[ROUND_COUNT-2:0]))
      else $error("valid bits did not shift along the chain");
  end

endmodule

[dv/tb_skinny64_64_encrypt_unit.sv]
// Self-checking testbench for the SKINNY-64-64 encryption pipeline with stream handshakes.
module tb_skinny64_64_encrypt_unit;
  import skinny_pkg::*;

  localparam int Rounds = 32;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [63:0] s_axis_tdata = '0;   // [63:0] plaintext
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;        // [63:0] ciphertext
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [63:0] cfg_data_i = '0;     // [63:0] tweakey

  // Tweakey as seen by the block, ciphertexts still owed, and the failure count.
  blk_t tweakey_q = '0;
  blk_t ct_expected [$];
  int   mismatches = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;

  // Directed vectors: a tweakey load happens only while the pipeline is drained.
  typedef struct packed {
    logic load_key;
    blk_t key;
    blk_t pt;
  } vec_t;

  localparam int NumVecs = 16;
  localparam vec_t DirectedVecs [NumVecs] = '{
    '{1'b0, 64'h0000000000000000, 64'h0000000000000000},
    '{1'b0, 64'h0000000000000000, 64'hffffffffffffffff},
    '{1'b0, 64'h0000000000000000, 64'h8000000000000000},
    '{1'b0, 64'h0000000000000000, 64'h0000000000000001},
    '{1'b0, 64'h0000000000000000, 64'haaaaaaaaaaaaaaaa},
    '{1'b0, 64'h0000000000000000, 64'h5555555555555555},
    '{1'b1, 64'hffffffffffffffff, 64'h0000000000000000},
    '{1'b0, 64'hffffffffffffffff, 64'hffffffffffffffff},
    '{1'b0, 64'hffffffffffffffff, 64'h0123456789abcdef},
    '{1'b0, 64'hffffffffffffffff, 64'hfedcba9876543210},
    '{1'b1, 64'h8000000000000000, 64'h0000000000000000},
    '{1'b1, 64'h0000000000000001, 64'h0000000000000000},
    '{1'b1, 64'hf5269826fc681238, 64'h06034f957724d19d},
    '{1'b0, 64'hf5269826fc681238, 64'h00000000ffffffff},
    '{1'b1, 64'h0123456789abcdef, 64'hffffffff00000000},
    '{1'b1, 64'h0000000000000000, 64'h0123456789abcdef}
  };

  skinny64_64_encrypt_unit #(
    .ROUND_COUNT(Rounds)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  // Clock with a period of 10 time units.
  initial begin
    forever begin
      #5 clk_i = ~clk_i;
    end
  end

  // Full encryption of one block, cell 0 in the top nibble.
  function automatic blk_t skinny_encrypt(blk_t pt, blk_t key);
    nib_t st [NumCells];
    nib_t tk [NumCells];
    nib_t tmp [NumCells];
    nib_t a, b, c, d;
    rc_t  rc;
    blk_t ct;
    for (int i = 0; i < NumCells; i++) begin
      st[i] = pt[63-4*i -: 4];
      tk[i] = key[63-4*i -: 4];
    end
    for (int r = 0; r < Rounds; r++) begin
      for (int i = 0; i < NumCells; i++) begin
        st[i] = SBOX[st[i]];
      end
      rc = RCONST[r];
      st[0] = st[0] ^ rc[3:0];
      st[4] = st[4] ^ {2'b00, rc[5:4]};
      st[8] = st[8] ^ RowTwoRc;
      // Only the top two rows take the round tweakey; then the schedule advances.
      for (int i = 0; i < 8; i++) begin
        st[i] = st[i] ^ tk[i];
      end
      tmp = tk;
      for (int i = 0; i < NumCells; i++) begin
        tk[i] = tmp[TK_PERM[i]];
      end
      tmp = st;
      for (int i = 0; i < NumCells; i++) begin
        st[i] = tmp[ROW_SHIFT[i]];
      end
      for (int i = 0; i < 4; i++) begin
        a = st[i];
        b = st[4+i];
        c = st[8+i];
        d = st[12+i];
        st[i]    = a ^ c ^ d;
        st[4+i]  = a;
        st[8+i]  = b ^ c;
        st[12+i] = a ^ c;
      end
    end
    for (int i = 0; i < NumCells; i++) begin
      ct[63-4*i -: 4] = st[i];
    end
    return ct;
  endfunction

  // Random block, now and then a single set or cleared bit or a solid pattern.
  function automatic blk_t random_block();
    blk_t v;
    int   pick;
    v = {$urandom, $urandom};
    pick = $urandom_range(15);
    if (pick == 0) begin
      v = blk_t'(1) << $urandom_range(63);
    end else if (pick == 1) begin
      v = ~(blk_t'(1) << $urandom_range(63));
    end else if (pick == 2) begin
      v = ($urandom_range(1) == 1) ? '1 : '0;
    end
    return v;
  endfunction

  // Output side: random stalls at the current rate.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Observe every transaction: track the tweakey, predict on input, check on output.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        tweakey_q <= cfg_data_i;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        ct_expected.push_back(skinny_encrypt(s_axis_tdata, tweakey_q));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (ct_expected.size() == 0) begin
          $display("%0t: unexpected ciphertext, expected none, actual %h", $time, m_axis_tdata);
          mismatches++;
        end else if (ct_expected[0] !== m_axis_tdata) begin
          $display("%0t: ciphertext mismatch, expected %h, actual %h",
                   $time, ct_expected[0], m_axis_tdata);
          mismatches++;
          void'(ct_expected.pop_front());
        end else begin
          void'(ct_expected.pop_front());
        end
      end
    end
  end

  // Offer one plaintext after random idle cycles and wait for its transaction.
  task automatic send_block(input blk_t pt);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pt;
    @(posedge clk_i);
    while (!s_axis_tready) begin
      @(posedge clk_i);
    end
  endtask

  // Stop offering blocks and let the pipeline drain completely.
  // The first wait lets the monitor record a transaction taken at the last edge.
  task automatic drain_pipeline();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (ct_expected.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (Rounds + 4) @(posedge clk_i);
  endtask

  // Load a new tweakey through the configuration channel.
  task automatic load_tweakey(input blk_t key);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= key;
    @(posedge clk_i);
    while (!cfg_ready_o) begin
      @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Stimulus: directed vectors, then three random phases with different stall patterns.
  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int n = 0; n < NumVecs; n++) begin
      if (DirectedVecs[n].load_key) begin
        drain_pipeline();
        load_tweakey(DirectedVecs[n].key);
      end
      send_block(DirectedVecs[n].pt);
    end

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 56 : 0;
      recv_idle_pct = (phase == 0) ? 56 : (phase == 1) ? 33 : 0;
      for (int n = 0; n < 250; n++) begin
        // Fresh tweakey every 50 blocks, loaded only once the pipeline is empty.
        if (n % 50 == 0) begin
          drain_pipeline();
          load_tweakey(random_block());
        end
        send_block(random_block());
      end
    end

    drain_pipeline();
    if (mismatches == 0) begin
      $display("[skinny64_64_encrypt_unit] OK");
    end else begin
      $display("[skinny64_64_encrypt_unit] ERROR");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("[skinny64_64_encrypt_unit] ERROR");
    $finish;
  end

endmodule

[files.f]
rtl/skinny_pkg.sv
rtl/skinny_round_cell.sv
rtl/skinny64_64_encrypt_unit.sv
dv/tb_skinny64_64_encrypt_unit.sv
